@@ rtl/afc_pkg.sv @@
`timescale 1ns / 1ps

package afc_pkg;

	localparam int REG_COUNT    = 6;
	localparam int CFG_W        = 64;
	localparam int CFG_IDX_W    = 3;
	localparam int COORD_W      = 16;
	localparam int EXT_W        = 15;
	localparam int COEF_W       = 16;
	localparam int PROD_W       = 2 * COEF_W;
	localparam int RPROD_W      = COEF_W + EXT_W;
	localparam int DIST_W       = PROD_W + 3;
	localparam int RAD_W        = RPROD_W + 2;
	localparam int CMP_W        = DIST_W + 2;
	localparam int OFFSET_SHIFT = 14;
	localparam int VERDICT_W    = 2;

	typedef enum logic [VERDICT_W-1:0] {
		VERDICT_INSIDE    = 2'd0,
		VERDICT_INTERSECT = 2'd1,
		VERDICT_OUTSIDE   = 2'd2
	} verdict_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] dd;
		logic signed [COEF_W-1:0]  c;
		logic signed [COEF_W-1:0]  b;
		logic signed [COEF_W-1:0]  a;
	} plane_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] center_x;
		logic signed [COORD_W-1:0] center_y;
		logic signed [COORD_W-1:0] center_z;
		logic [EXT_W-1:0]          extent_x;
		logic [EXT_W-1:0]          extent_y;
		logic [EXT_W-1:0]          extent_z;
	} box_t;

	typedef struct packed {
		logic outside;
		logic straddle;
	} plane_flags_t;

	function automatic logic [COEF_W-1:0] coef_mag(input logic signed [COEF_W-1:0] v);
		logic signed [COEF_W-1:0] neg;
		neg = -v;
		return v[COEF_W-1] ? COEF_W'(neg) : COEF_W'(v);
	endfunction

endpackage

@@ rtl/afc_plane_lane.sv @@
`timescale 1ns / 1ps

module afc_plane_lane
	import afc_pkg::*;
(
	input  logic         clk,
	input  plane_t       plane,
	input  box_t         box,
	output plane_flags_t flags_s3
);

	logic signed [PROD_W-1:0]  prod_x_s1;
	logic signed [PROD_W-1:0]  prod_y_s1;
	logic signed [PROD_W-1:0]  prod_z_s1;
	logic [RPROD_W-1:0]        rprod_x_s1;
	logic [RPROD_W-1:0]        rprod_y_s1;
	logic [RPROD_W-1:0]        rprod_z_s1;
	logic signed [COORD_W-1:0] offset_s1;
	logic signed [DIST_W-1:0]  dist_s2;
	logic [RAD_W-1:0]          rad_s2;
	logic [CMP_W-1:0]          far_sum;
	logic [CMP_W-1:0]          near_diff;

	always_ff @(posedge clk) begin
		prod_x_s1  <= plane.a * box.center_x;
		prod_y_s1  <= plane.b * box.center_y;
		prod_z_s1  <= plane.c * box.center_z;
		rprod_x_s1 <= coef_mag(plane.a) * box.extent_x;
		rprod_y_s1 <= coef_mag(plane.b) * box.extent_y;
		rprod_z_s1 <= coef_mag(plane.c) * box.extent_z;
		offset_s1  <= plane.dd;
	end

	always_ff @(posedge clk) begin
		dist_s2 <= DIST_W'(prod_x_s1) + DIST_W'(prod_y_s1) + DIST_W'(prod_z_s1)
			+ (DIST_W'(offset_s1) <<< OFFSET_SHIFT);
		rad_s2  <= RAD_W'(rprod_x_s1) + RAD_W'(rprod_y_s1) + RAD_W'(rprod_z_s1);
	end

	assign far_sum   = CMP_W'(dist_s2) + CMP_W'(rad_s2);
	assign near_diff = CMP_W'(dist_s2) - CMP_W'(rad_s2);

	always_ff @(posedge clk) begin
		flags_s3.outside  <= far_sum[CMP_W-1];
		flags_s3.straddle <= near_diff[CMP_W-1];
	end

endmodule

@@ rtl/afc_verdict.sv @@
`timescale 1ns / 1ps

module afc_verdict
	import afc_pkg::*;
#(
	parameter int PLANE_COUNT = 6
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           valid_s3,
	input  plane_flags_t [PLANE_COUNT-1:0] flags_s3,
	output logic                           done_s4,
	output verdict_t                       verdict_s4
);

	logic     any_outside;
	logic     any_straddle;
	verdict_t verdict_d;

	always_comb begin
		any_outside  = 1'b0;
		any_straddle = 1'b0;
		for (int p = 0; p < PLANE_COUNT; p++) begin
			any_outside  = any_outside | flags_s3[p].outside;
			any_straddle = any_straddle | flags_s3[p].straddle;
		end
		priority if (any_outside) begin
			verdict_d = VERDICT_OUTSIDE;
		end else if (any_straddle) begin
			verdict_d = VERDICT_INTERSECT;
		end else begin
			verdict_d = VERDICT_INSIDE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s4 <= 1'b0;
		end else begin
			done_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		verdict_s4 <= verdict_d;
	end

	a_outside_wins: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s3 && any_outside) |=> (done_s4 && verdict_s4 == VERDICT_OUTSIDE))
		else $error("A box outside one plane was not reported as outside.");

	a_clear_is_inside: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s3 && !any_straddle) |=> (verdict_s4 == VERDICT_INSIDE))
		else $error("A box within every plane was not reported as inside.");

endmodule

@@ rtl/aabb_frustum_cull.sv @@
`timescale 1ns / 1ps

// Channel   Direction  Handshake         Payload
// command   in         start, busy       center_x/y/z, extent_x/y/z
// result    out        done              verdict
// config    in         cfg_we            cfg_index, cfg_data
//
// One item is taken in every cycle; busy never rises.
// The verdict for an item appears with done after the product, sum and compare stages
// of the plane lanes and the combine stage of the verdict block.
// Reset clears the plane registers and the valid bits of the pipeline.
// The result side cannot stall, so the pipeline always advances.

module aabb_frustum_cull
	import afc_pkg::*;
#(
	parameter int PLANE_COUNT = 6
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic signed [COORD_W-1:0] center_x,
	input  logic signed [COORD_W-1:0] center_y,
	input  logic signed [COORD_W-1:0] center_z,
	input  logic [EXT_W-1:0]          extent_x,
	input  logic [EXT_W-1:0]          extent_y,
	input  logic [EXT_W-1:0]          extent_z,
	output logic                      done,
	output logic [VERDICT_W-1:0]      verdict,
	input  logic                      cfg_we,
	input  logic [CFG_IDX_W-1:0]      cfg_index,
	input  logic [CFG_W-1:0]          cfg_data
);

	plane_t                         plane_q [REG_COUNT];
	box_t                           box;
	logic                           valid_s1;
	logic                           valid_s2;
	logic                           valid_s3;
	plane_flags_t [PLANE_COUNT-1:0] flags_s3;
	verdict_t                       verdict_s4;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < REG_COUNT; i++) begin
				plane_q[i] <= '0;
			end
		end else if (cfg_we) begin
			for (int i = 0; i < REG_COUNT; i++) begin
				if (cfg_index == CFG_IDX_W'(i)) begin
					plane_q[i] <= plane_t'(cfg_data);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	assign box.center_x = center_x;
	assign box.center_y = center_y;
	assign box.center_z = center_z;
	assign box.extent_x = extent_x;
	assign box.extent_y = extent_y;
	assign box.extent_z = extent_z;

	for (genvar p = 0; p < PLANE_COUNT; p++) begin : g_lane
		plane_t plane;

		if (p < REG_COUNT) begin : g_reg
			assign plane = plane_q[p];
		end else begin : g_zero
			assign plane = '0;
		end

		afc_plane_lane u_lane (
			.clk      (clk),
			.plane    (plane),
			.box      (box),
			.flags_s3 (flags_s3[p])
		);
	end

	afc_verdict #(
		.PLANE_COUNT (PLANE_COUNT)
	) u_verdict (
		.clk        (clk),
		.arst_n     (arst_n),
		.valid_s3   (valid_s3),
		.flags_s3   (flags_s3),
		.done_s4    (done),
		.verdict_s4 (verdict_s4)
	);

	assign verdict = VERDICT_W'(verdict_s4);

	a_done_follows_start: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 4))
		else $error("A result appeared without an item taken four cycles earlier.");

endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps

module tb;
	import afc_pkg::*;

	localparam int PLANES      = 6;
	localparam int LATENCY     = 4;
	localparam int STALL_LIMIT = 200;
	localparam int PHASES      = 10;
	localparam int PHASE_ITEMS = 65;

	typedef enum logic {
		ROW_CFG,
		ROW_BOX
	} row_kind_t;

	typedef struct packed {
		row_kind_t             kind;
		logic [CFG_IDX_W-1:0]  idx;
		logic [CFG_W-1:0]      data;
		box_t                  bx;
		logic                  typed;
		verdict_t              verdict;
	} row_t;

	logic                      clk;
	logic                      arst_n;
	logic                      start;
	logic                      busy;
	logic signed [COORD_W-1:0] center_x;
	logic signed [COORD_W-1:0] center_y;
	logic signed [COORD_W-1:0] center_z;
	logic [EXT_W-1:0]          extent_x;
	logic [EXT_W-1:0]          extent_y;
	logic [EXT_W-1:0]          extent_z;
	logic                      done;
	logic [VERDICT_W-1:0]      verdict;
	logic                      cfg_we;
	logic [CFG_IDX_W-1:0]      cfg_index;
	logic [CFG_W-1:0]          cfg_data;

	logic     typed_ok;
	verdict_t typed_verdict;
	bit       no_gaps;

	plane_t   plane_regs [8];
	verdict_t pending_verdicts [$];
	row_t     directed_rows [$];
	int       mismatches;
	int       stall_cycles;

	aabb_frustum_cull #(.PLANE_COUNT(PLANES)) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.center_x (center_x),
		.center_y (center_y),
		.center_z (center_z),
		.extent_x (extent_x),
		.extent_y (extent_y),
		.extent_z (extent_z),
		.done     (done),
		.verdict  (verdict),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	function automatic verdict_t classify_box(input box_t bx);
		longint a, b, c, dd, cx, cy, cz, ex, ey, ez, plane_dist, rad;
		bit outside, straddle;
		outside  = 1'b0;
		straddle = 1'b0;
		cx = $signed(bx.center_x);
		cy = $signed(bx.center_y);
		cz = $signed(bx.center_z);
		ex = bx.extent_x;
		ey = bx.extent_y;
		ez = bx.extent_z;
		for (int i = 0; i < PLANES; i++) begin
			a  = $signed(plane_regs[i].a);
			b  = $signed(plane_regs[i].b);
			c  = $signed(plane_regs[i].c);
			dd = $signed(plane_regs[i].dd);
			plane_dist = a * cx + b * cy + c * cz + dd * 16384;
			rad  = ((a < 0) ? -a : a) * ex + ((b < 0) ? -b : b) * ey
				+ ((c < 0) ? -c : c) * ez;
			if (plane_dist + rad < 0) begin
				outside = 1'b1;
			end else if (plane_dist - rad < 0) begin
				straddle = 1'b1;
			end
		end
		if (outside) begin
			return VERDICT_OUTSIDE;
		end else if (straddle) begin
			return VERDICT_INTERSECT;
		end
		return VERDICT_INSIDE;
	endfunction

	function automatic logic [CFG_W-1:0] mk_plane(input int a, input int b, input int c,
		input int dd);
		plane_t p;
		p.a  = COEF_W'(a);
		p.b  = COEF_W'(b);
		p.c  = COEF_W'(c);
		p.dd = COORD_W'(dd);
		return p;
	endfunction

	function automatic row_t box_row(input int cx, input int cy, input int cz, input int ex,
		input int ey, input int ez, input logic typed, input verdict_t v);
		row_t r;
		r = '0;
		r.kind           = ROW_BOX;
		r.bx.center_x    = COORD_W'(cx);
		r.bx.center_y    = COORD_W'(cy);
		r.bx.center_z    = COORD_W'(cz);
		r.bx.extent_x    = EXT_W'(ex);
		r.bx.extent_y    = EXT_W'(ey);
		r.bx.extent_z    = EXT_W'(ez);
		r.typed          = typed;
		r.verdict        = v;
		return r;
	endfunction

	function automatic row_t cfg_row(input int idx, input logic [CFG_W-1:0] data);
		row_t r;
		r = '0;
		r.kind = ROW_CFG;
		r.idx  = CFG_IDX_W'(idx);
		r.data = data;
		return r;
	endfunction

	function automatic int rand_coef();
		return int'($urandom_range(0, 32768)) - 16384;
	endfunction

	function automatic logic [CFG_W-1:0] random_plane();
		int pick, axis, unit;
		pick = $urandom_range(0, 9);
		if (pick < 6) begin
			return mk_plane(rand_coef(), rand_coef(), rand_coef(), $urandom_range(0, 4096));
		end
		if (pick < 8) begin
			axis = $urandom_range(0, 2);
			unit = $urandom_range(0, 1) ? 16384 : -16384;
			return mk_plane(axis == 0 ? unit : 0, axis == 1 ? unit : 0, axis == 2 ? unit : 0,
				$urandom_range(0, 3200));
		end
		if (pick == 8) begin
			return {$urandom, $urandom};
		end
		return '0;
	endfunction

	function automatic box_t random_box();
		box_t bx;
		if ($urandom_range(0, 3) == 0) begin
			bx.center_x = COORD_W'($urandom);
			bx.center_y = COORD_W'($urandom);
			bx.center_z = COORD_W'($urandom);
			bx.extent_x = EXT_W'($urandom);
			bx.extent_y = EXT_W'($urandom);
			bx.extent_z = EXT_W'($urandom);
		end else begin
			bx.center_x = COORD_W'(int'($urandom_range(0, 8191)) - 4096);
			bx.center_y = COORD_W'(int'($urandom_range(0, 8191)) - 4096);
			bx.center_z = COORD_W'(int'($urandom_range(0, 8191)) - 4096);
			if ($urandom_range(0, 7) == 0) begin
				bx.extent_x = '0;
				bx.extent_y = '0;
				bx.extent_z = '0;
			end else begin
				bx.extent_x = EXT_W'($urandom_range(0, 1023));
				bx.extent_y = EXT_W'($urandom_range(0, 1023));
				bx.extent_z = EXT_W'($urandom_range(0, 1023));
			end
		end
		return bx;
	endfunction

	task automatic send_box(input box_t bx, input logic typed, input verdict_t v);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 4);
		@(negedge clk);
		if (gap != 0) begin
			start = 1'b0;
			repeat (gap) @(negedge clk);
		end
		start         = 1'b1;
		center_x      = bx.center_x;
		center_y      = bx.center_y;
		center_z      = bx.center_z;
		extent_x      = bx.extent_x;
		extent_y      = bx.extent_y;
		extent_z      = bx.extent_z;
		typed_ok      = typed;
		typed_verdict = v;
		do @(posedge clk); while (busy);
	endtask

	task automatic drain_pipeline();
		@(negedge clk);
		start    = 1'b0;
		typed_ok = 1'b0;
		while (pending_verdicts.size() != 0) @(posedge clk);
		repeat (LATENCY) @(posedge clk);
	endtask

	task automatic write_plane(input int idx, input logic [CFG_W-1:0] value);
		@(negedge clk);
		cfg_we    = 1'b1;
		cfg_index = CFG_IDX_W'(idx);
		cfg_data  = value;
		@(posedge clk);
		if (idx < REG_COUNT) begin
			plane_regs[idx] = value;
		end
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (done) begin
				if (pending_verdicts.size() == 0) begin
					$error("verdict: no item pending, actual %0d", verdict);
					mismatches++;
				end else if (verdict !== pending_verdicts[0]) begin
					$error("verdict: expected %0d, actual %0d", pending_verdicts[0], verdict);
					mismatches++;
					void'(pending_verdicts.pop_front());
				end else begin
					void'(pending_verdicts.pop_front());
				end
			end
			if (start && !busy) begin
				pending_verdicts.push_back(typed_ok ? typed_verdict
					: classify_box({center_x, center_y, center_z, extent_x, extent_y, extent_z}));
			end
			if ((start && !busy) || done) begin
				stall_cycles = 0;
			end else begin
				stall_cycles++;
			end
		end
	end

	initial begin
		wait (stall_cycles >= STALL_LIMIT);
		$display("tb: FAIL");
		$finish;
	end

	initial begin
		logic [CFG_W-1:0] fill;
		arst_n        = 1'b0;
		start         = 1'b0;
		center_x      = '0;
		center_y      = '0;
		center_z      = '0;
		extent_x      = '0;
		extent_y      = '0;
		extent_z      = '0;
		cfg_we        = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		typed_ok      = 1'b0;
		typed_verdict = VERDICT_INSIDE;
		no_gaps       = 1'b0;
		mismatches    = 0;
		stall_cycles  = 0;
		foreach (plane_regs[i]) plane_regs[i] = '0;

		// After reset every plane is zero, so nothing is ever excluded.
		directed_rows.push_back(box_row(0, 0, 0, 0, 0, 0, 1'b1, VERDICT_INSIDE));
		directed_rows.push_back(box_row(32767, 32767, 32767, 32767, 32767, 32767, 1'b1,
			VERDICT_INSIDE));
		directed_rows.push_back(box_row(-32768, -32768, -32768, 0, 0, 0, 1'b1, VERDICT_INSIDE));
		// A single half-space x >= 0 on the left plane.
		directed_rows.push_back(cfg_row(0, mk_plane(16384, 0, 0, 0)));
		directed_rows.push_back(box_row(16, 0, 0, 0, 0, 0, 1'b1, VERDICT_INSIDE));
		directed_rows.push_back(box_row(-16, 0, 0, 0, 0, 0, 1'b1, VERDICT_OUTSIDE));
		directed_rows.push_back(box_row(-16, 0, 0, 32, 0, 0, 1'b1, VERDICT_INTERSECT));
		directed_rows.push_back(box_row(0, 0, 0, 0, 0, 0, 1'b1, VERDICT_INSIDE));
		directed_rows.push_back(box_row(32767, 0, 0, 32767, 0, 0, 1'b1, VERDICT_INSIDE));
		directed_rows.push_back(box_row(-32768, 0, 0, 32767, 0, 0, 1'b1, VERDICT_OUTSIDE));
		directed_rows.push_back(box_row(-32768, 5, 5, 0, 32767, 32767, 1'b1, VERDICT_OUTSIDE));
		// A zero normal with a negative offset rejects everything.
		directed_rows.push_back(cfg_row(1, mk_plane(0, 0, 0, -1)));
		directed_rows.push_back(box_row(100, 100, 100, 10, 10, 10, 1'b1, VERDICT_OUTSIDE));
		// Writes to indexes past the last plane must be dropped.
		directed_rows.push_back(cfg_row(1, '0));
		directed_rows.push_back(cfg_row(6, '1));
		directed_rows.push_back(cfg_row(7, '1));
		directed_rows.push_back(box_row(0, 0, 0, 0, 0, 0, 1'b1, VERDICT_INSIDE));
		directed_rows.push_back(cfg_row(0, mk_plane(16384, 0, 0, 1600)));
		directed_rows.push_back(cfg_row(1, mk_plane(-16384, 0, 0, 1600)));
		directed_rows.push_back(cfg_row(2, mk_plane(0, -16384, 0, 1600)));
		directed_rows.push_back(cfg_row(3, mk_plane(0, 16384, 0, 1600)));
		directed_rows.push_back(cfg_row(4, mk_plane(0, 0, 16384, -16)));
		directed_rows.push_back(cfg_row(5, mk_plane(0, 0, -16384, 1600)));
		directed_rows.push_back(box_row(0, 0, 160, 16, 16, 16, 1'b0, VERDICT_INSIDE));
		directed_rows.push_back(box_row(1600, 0, 160, 16, 16, 16, 1'b0, VERDICT_INSIDE));
		directed_rows.push_back(box_row(0, 0, 0, 0, 0, 0, 1'b0, VERDICT_INSIDE));
		directed_rows.push_back(box_row(-5000, 0, 100, 0, 0, 0, 1'b0, VERDICT_INSIDE));
		directed_rows.push_back(box_row(0, 0, 1600, 32767, 32767, 32767, 1'b0, VERDICT_INSIDE));
		// Most negative normals, whose magnitude does not fit the signed range.
		directed_rows.push_back(cfg_row(0, mk_plane(-32768, -32768, -32768, 32767)));
		directed_rows.push_back(cfg_row(1, mk_plane(32767, 32767, 32767, -32768)));
		directed_rows.push_back(cfg_row(2, '0));
		directed_rows.push_back(cfg_row(3, '0));
		directed_rows.push_back(cfg_row(4, '0));
		directed_rows.push_back(cfg_row(5, '0));
		directed_rows.push_back(box_row(-32768, -32768, -32768, 32767, 32767, 32767, 1'b0,
			VERDICT_INSIDE));
		directed_rows.push_back(box_row(32767, 32767, 32767, 0, 0, 0, 1'b0, VERDICT_INSIDE));
		directed_rows.push_back(box_row(100, -100, 50, 3, 3, 3, 1'b0, VERDICT_INSIDE));
		directed_rows.push_back(box_row(-1, -1, -1, 1, 1, 1, 1'b0, VERDICT_INSIDE));

		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_CFG) begin
				drain_pipeline();
				write_plane(directed_rows[i].idx, directed_rows[i].data);
			end else begin
				send_box(directed_rows[i].bx, directed_rows[i].typed, directed_rows[i].verdict);
			end
		end

		for (int phase = 0; phase < PHASES; phase++) begin
			drain_pipeline();
			no_gaps = (phase % 3 == 1);
			case (phase)
				0: fill = '0;
				1: fill = '1;
				2: fill = {4{16'h8000}};
				3: fill = {4{16'h7fff}};
				default: fill = '0;
			endcase
			for (int idx = 0; idx < REG_COUNT; idx++) begin
				write_plane(idx, phase < 4 ? fill : random_plane());
			end
			if ($urandom_range(0, 2) == 0) begin
				write_plane($urandom_range(REG_COUNT, 7), {$urandom, $urandom});
			end
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				send_box(random_box(), 1'b0, VERDICT_INSIDE);
			end
		end

		drain_pipeline();
		if (mismatches == 0) begin
			$display("tb: PASS");
		end else begin
			$display("tb: FAIL");
		end
		$finish;
	end

endmodule
